// ----- hw/rtl/tlsg_pkg.sv -----
// Package for the teleop lease safety gate: item kinds, register indexes,
// reset values and joint types. No dependencies.
package tlsg_pkg;

  localparam int unsigned JointCount = 6;
  localparam int unsigned PosW       = 16;
  localparam int unsigned TimeoutW   = 16;
  localparam int unsigned LeaseW     = 11;
  localparam int unsigned LimitW     = 48;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 48;
  localparam int unsigned PerReg     = 3;

  typedef logic signed [PosW-1:0] joint_t;

  typedef enum logic [1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_ENABLE  = 2'd1,
    REQ_TICK    = 2'd2,
    REQ_PUBLISH = 2'd3
  } req_type_e;

  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LEASE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOWER_A = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LOWER_B = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_UPPER_A = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_UPPER_B = 3'd5;

  localparam logic [TimeoutW-1:0] RST_TIMEOUT = 16'd500;
  localparam logic [LeaseW-1:0]   RST_LEASE   = 11'd1000;
  localparam logic [LimitW-1:0]   RST_LOWER_A = 48'd252453506965299;
  localparam logic [LimitW-1:0]   RST_LOWER_B = 48'd883933832192;
  localparam logic [LimitW-1:0]   RST_UPPER_A = 48'd24627798810829;
  localparam logic [LimitW-1:0]   RST_UPPER_B = 48'd29026218482688;

  localparam logic [TimeoutW-1:0] AGE_MAX = '1;

  localparam logic REPLY_ENABLE  = 1'b0;
  localparam logic REPLY_COMMAND = 1'b1;

endpackage

// ----- hw/rtl/teleop_lease_safety_gate_core.sv -----
// Teleop lease safety gate: limit check, lease and staleness tracking,
// publish gating. Depends on tlsg_pkg.
//
// Channel  Dir  Handshake               Payload
// in       in   in_valid_i/in_ready_o   req_type_i, enable_wanted_i, joint_in_0..5_i
// out      out  out_valid_o/out_ready_i reply_kind_o, granted_o, lease_active_o,
//                                       joint_out_0..5_o
// cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle unless a result waits on a held output register: an input
// register feeds one pass of compare and counter logic, whose result lands in the output register.
// Items with no result never wait on the output side; an item with a result
// waits in the input register only while the output register is held.
// Reset is asynchronous, active low; the cfg port is always ready.
module teleop_lease_safety_gate_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [1:0]                             req_type_i,
  input  logic                                   enable_wanted_i,
  input  logic signed [15:0]                     joint_in_0_i,
  input  logic signed [15:0]                     joint_in_1_i,
  input  logic signed [15:0]                     joint_in_2_i,
  input  logic signed [15:0]                     joint_in_3_i,
  input  logic signed [15:0]                     joint_in_4_i,
  input  logic signed [15:0]                     joint_in_5_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   reply_kind_o,
  output logic                                   granted_o,
  output logic                                   lease_active_o,
  output logic signed [15:0]                     joint_out_0_o,
  output logic signed [15:0]                     joint_out_1_o,
  output logic signed [15:0]                     joint_out_2_o,
  output logic signed [15:0]                     joint_out_3_o,
  output logic signed [15:0]                     joint_out_4_o,
  output logic signed [15:0]                     joint_out_5_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [tlsg_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [tlsg_pkg::CfgDataW-1:0]          cfg_data_i
);
  import tlsg_pkg::*;

  // configuration
  logic [TimeoutW-1:0] timeout_q;
  logic [LeaseW-1:0]   lease_len_q;
  logic [LimitW-1:0]   lo_a_q, lo_b_q, hi_a_q, hi_b_q;

  // input stage
  logic      in_vld_q;
  req_type_e in_type_q;
  logic      in_want_q;
  joint_t    in_joint_q [JointCount];
  joint_t    in_joint   [JointCount];

  // gate state
  joint_t              pos_q [JointCount];
  logic                complete_q, complete_d;
  logic [TimeoutW-1:0] age_q, age_d;
  logic                enabled_q, enabled_d;
  logic [LeaseW-1:0]   lease_q, lease_d;

  // output stage
  logic   out_vld_q;
  logic   out_kind_q, out_granted_q, out_active_q;
  joint_t out_joint_q [JointCount];

  logic   data_fresh, lease_fresh, in_range, has_result, out_free, proc;
  logic   latch, ok;
  joint_t lo [JointCount];
  joint_t hi [JointCount];

  assign in_joint[0] = joint_in_0_i;
  assign in_joint[1] = joint_in_1_i;
  assign in_joint[2] = joint_in_2_i;
  assign in_joint[3] = joint_in_3_i;
  assign in_joint[4] = joint_in_4_i;
  assign in_joint[5] = joint_in_5_i;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= RST_TIMEOUT;
      lease_len_q <= RST_LEASE;
      lo_a_q      <= RST_LOWER_A;
      lo_b_q      <= RST_LOWER_B;
      hi_a_q      <= RST_UPPER_A;
      hi_b_q      <= RST_UPPER_B;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TIMEOUT: timeout_q   <= cfg_data_i[TimeoutW-1:0];
        CFG_LEASE:   lease_len_q <= cfg_data_i[LeaseW-1:0];
        CFG_LOWER_A: lo_a_q      <= cfg_data_i[LimitW-1:0];
        CFG_LOWER_B: lo_b_q      <= cfg_data_i[LimitW-1:0];
        CFG_UPPER_A: hi_a_q      <= cfg_data_i[LimitW-1:0];
        CFG_UPPER_B: hi_b_q      <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int j = 0; j < PerReg; j++) begin
      lo[j]          = lo_a_q[PosW*j +: PosW];
      lo[j + PerReg] = lo_b_q[PosW*j +: PosW];
      hi[j]          = hi_a_q[PosW*j +: PosW];
      hi[j + PerReg] = hi_b_q[PosW*j +: PosW];
    end
  end

  always_comb begin
    in_range = 1'b1;
    for (int j = 0; j < JointCount; j++) begin
      if (in_joint_q[j] < lo[j] || in_joint_q[j] > hi[j]) begin
        in_range = 1'b0;
      end
    end
  end

  assign data_fresh  = complete_q && (age_q <= timeout_q);
  assign lease_fresh = enabled_q && (lease_q != '0);

  always_comb begin
    unique case (in_type_q)
      REQ_ENABLE:  has_result = 1'b1;
      REQ_PUBLISH: has_result = lease_fresh && data_fresh;
      REQ_SAMPLE,
      REQ_TICK:    has_result = 1'b0;
    endcase
  end

  assign out_free   = !out_vld_q || out_ready_i;
  assign proc       = in_vld_q && (!has_result || out_free);
  assign in_ready_o = !in_vld_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (proc) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_type_q  <= req_type_e'(req_type_i);
      in_want_q  <= enable_wanted_i;
      in_joint_q <= in_joint;
    end
  end

  always_comb begin
    complete_d = complete_q;
    age_d      = age_q;
    enabled_d  = enabled_q;
    lease_d    = lease_q;
    latch      = 1'b0;
    ok         = 1'b0;
    if (proc) begin
      unique case (in_type_q)
        REQ_SAMPLE: begin
          if (in_range) begin
            latch      = 1'b1;
            complete_d = 1'b1;
            age_d      = '0;
          end
        end
        REQ_ENABLE: begin
          priority if (in_want_q && !data_fresh) begin
            enabled_d = 1'b0;
          end else if (in_want_q) begin
            enabled_d = 1'b1;
            lease_d   = lease_len_q;
            ok        = 1'b1;
          end else begin
            enabled_d = 1'b0;
            lease_d   = '0;
            ok        = 1'b1;
          end
        end
        REQ_TICK: begin
          if (age_q != AGE_MAX) age_d = age_q + 1'b1;
          if (lease_q != '0)    lease_d = lease_q - 1'b1;
        end
        REQ_PUBLISH: begin
          if (!has_result) begin
            enabled_d = 1'b0;
            lease_d   = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      complete_q <= 1'b0;
      age_q      <= AGE_MAX;
      enabled_q  <= 1'b0;
      lease_q    <= '0;
      for (int j = 0; j < JointCount; j++) pos_q[j] <= '0;
    end else begin
      complete_q <= complete_d;
      age_q      <= age_d;
      enabled_q  <= enabled_d;
      lease_q    <= lease_d;
      if (latch) pos_q <= in_joint_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc && has_result) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && has_result) begin
      if (in_type_q == REQ_ENABLE) begin
        out_kind_q    <= REPLY_ENABLE;
        out_granted_q <= ok;
        out_active_q  <= enabled_d;
        for (int j = 0; j < JointCount; j++) out_joint_q[j] <= '0;
      end else begin
        out_kind_q    <= REPLY_COMMAND;
        out_granted_q <= 1'b0;
        out_active_q  <= 1'b1;
        out_joint_q   <= pos_q;
      end
    end
  end

  assign out_valid_o    = out_vld_q;
  assign reply_kind_o   = out_kind_q;
  assign granted_o      = out_granted_q;
  assign lease_active_o = out_active_q;
  assign joint_out_0_o  = out_joint_q[0];
  assign joint_out_1_o  = out_joint_q[1];
  assign joint_out_2_o  = out_joint_q[2];
  assign joint_out_3_o  = out_joint_q[3];
  assign joint_out_4_o  = out_joint_q[4];
  assign joint_out_5_o  = out_joint_q[5];

  a_cmd_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_kind_q == REPLY_COMMAND |-> out_active_q && !out_granted_q)
    else $error("joint command without active lease");

  a_refused_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_kind_q == REPLY_ENABLE && !out_granted_q |-> !out_active_q)
    else $error("refused grant left lease active");

  a_latch_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch |=> complete_q && age_q == '0)
    else $error("latched sample did not reset age");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |-> !(proc && has_result))
    else $error("result overwrote a pending output");

endmodule

// ----- test/teleop_lease_safety_gate_core_tb.sv -----
// Testbench for teleop_lease_safety_gate_core: directed and random items with
// a scoreboard that tracks limits, sample age and lease. Depends on tlsg_pkg
// and the core RTL.
`timescale 1ns / 100ps

module teleop_lease_safety_gate_core_tb;
  import tlsg_pkg::*;

  typedef logic [JointCount-1:0][PosW-1:0] pose_t;

  typedef struct packed {
    logic  kind;
    logic  granted;
    logic  active;
    pose_t pos;
  } reply_t;

  typedef enum {POSE_NOISE, POSE_FIT, POSE_MISS, POSE_LOWER, POSE_UPPER} pose_mode_e;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

  class gate_scoreboard;
    logic [TimeoutW-1:0] timeout;
    logic [LeaseW-1:0]   lease_len;
    logic [LimitW-1:0]   lower_a, lower_b, upper_a, upper_b;
    pose_t               latched;
    logic                complete;
    logic [TimeoutW-1:0] age;
    logic                enabled;
    logic [LeaseW-1:0]   lease_left;
    reply_t              replies[$];
    int                  errors;

    function new();
      timeout    = RST_TIMEOUT;
      lease_len  = RST_LEASE;
      lower_a    = RST_LOWER_A;
      lower_b    = RST_LOWER_B;
      upper_a    = RST_UPPER_A;
      upper_b    = RST_UPPER_B;
      latched    = '0;
      complete   = 1'b0;
      age        = AGE_MAX;
      enabled    = 1'b0;
      lease_left = '0;
      errors     = 0;
    endfunction

    function joint_t limit(logic upper_side, int j);
      logic [LimitW-1:0] r;
      if (upper_side) begin
        r = (j < PerReg) ? upper_a : upper_b;
      end else begin
        r = (j < PerReg) ? lower_a : lower_b;
      end
      return joint_t'(r[PosW*(j%PerReg) +: PosW]);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_TIMEOUT: timeout = data[TimeoutW-1:0];
        CFG_LEASE:   lease_len = data[LeaseW-1:0];
        CFG_LOWER_A: lower_a = data[LimitW-1:0];
        CFG_LOWER_B: lower_b = data[LimitW-1:0];
        CFG_UPPER_A: upper_a = data[LimitW-1:0];
        CFG_UPPER_B: upper_b = data[LimitW-1:0];
        default: ;
      endcase
    endfunction

    function void queue_reply(reply_t r);
      replies.insert(replies.size(), r);
    endfunction

    function void note_item(req_type_e kind, logic wanted, pose_t pos);
      reply_t r;
      logic   fits;
      logic   fresh;
      fresh = complete && (age <= timeout);
      r = '0;
      r.kind = REPLY_ENABLE;
      case (kind)
        REQ_SAMPLE: begin
          fits = 1'b1;
          for (int j = 0; j < JointCount; j++) begin
            if ($signed(pos[j]) < limit(1'b0, j) || $signed(pos[j]) > limit(1'b1, j))
              fits = 1'b0;
          end
          if (fits) begin
            latched  = pos;
            complete = 1'b1;
            age      = '0;
          end
        end
        REQ_ENABLE: begin
          if (wanted && !fresh) begin
            enabled   = 1'b0;
            r.granted = 1'b0;
          end else if (wanted) begin
            enabled    = 1'b1;
            lease_left = lease_len;
            r.granted  = 1'b1;
          end else begin
            enabled    = 1'b0;
            lease_left = '0;
            r.granted  = 1'b1;
          end
          r.active = enabled;
          queue_reply(r);
        end
        REQ_TICK: begin
          if (age != AGE_MAX) age = age + 1'b1;
          if (lease_left != '0) lease_left = lease_left - 1'b1;
        end
        default: begin
          if (enabled && lease_left != '0 && fresh) begin
            r.kind   = REPLY_COMMAND;
            r.active = 1'b1;
            r.pos    = latched;
            queue_reply(r);
          end else begin
            enabled    = 1'b0;
            lease_left = '0;
          end
        end
      endcase
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (replies.size() == 0) begin
        $error("unexpected transaction: reply_kind %0d", got.kind);
        errors++;
        return;
      end
      want = replies.pop_front();
      if (got.kind !== want.kind) begin
        $error("reply_kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.granted !== want.granted) begin
        $error("granted: expected %0d, actual %0d", want.granted, got.granted);
        errors++;
      end
      if (got.active !== want.active) begin
        $error("lease_active: expected %0d, actual %0d", want.active, got.active);
        errors++;
      end
      for (int j = 0; j < JointCount; j++) begin
        if (got.pos[j] !== want.pos[j]) begin
          $error("joint_out_%0d: expected %0d, actual %0d", j,
                 $signed(want.pos[j]), $signed(got.pos[j]));
          errors++;
        end
      end
    endfunction

    function int pending();
      return replies.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  req_type_e            req_type_i;
  logic                 enable_wanted_i;
  pose_t                joint_drv;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 reply_kind_o;
  logic                 granted_o;
  logic                 lease_active_o;
  wire pose_t           cmd_pos;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  gate_scoreboard sb;
  int             sent;
  int             stall_cycles;
  bit             calm;

  teleop_lease_safety_gate_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .enable_wanted_i (enable_wanted_i),
    .joint_in_0_i    (joint_drv[0]),
    .joint_in_1_i    (joint_drv[1]),
    .joint_in_2_i    (joint_drv[2]),
    .joint_in_3_i    (joint_drv[3]),
    .joint_in_4_i    (joint_drv[4]),
    .joint_in_5_i    (joint_drv[5]),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .reply_kind_o    (reply_kind_o),
    .granted_o       (granted_o),
    .lease_active_o  (lease_active_o),
    .joint_out_0_o   (cmd_pos[0]),
    .joint_out_1_o   (cmd_pos[1]),
    .joint_out_2_o   (cmd_pos[2]),
    .joint_out_3_o   (cmd_pos[3]),
    .joint_out_4_o   (cmd_pos[4]),
    .joint_out_5_o   (cmd_pos[5]),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // transaction monitors: values seen here are the ones before the edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_reply(reply_t'({reply_kind_o, granted_o, lease_active_o, cmd_pos}));
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_item(req_type_i, enable_wanted_i, joint_drv);
    if (rst_ni && cfg_valid_i && cfg_ready_o)
      sb.write_reg(cfg_index_i, cfg_data_i);
  end

  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_cycles > 0) begin
        stall_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 15);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic pose_t pick_pose(pose_mode_e mode);
    pose_t p;
    int    lo, hi, bad;
    for (int j = 0; j < JointCount; j++) begin
      lo = sb.limit(1'b0, j);
      hi = sb.limit(1'b1, j);
      case (mode)
        POSE_LOWER: p[j] = PosW'(lo);
        POSE_UPPER: p[j] = PosW'(hi);
        POSE_FIT, POSE_MISS: begin
          if (lo > hi) begin
            p[j] = PosW'($urandom);
          end else begin
            case ($urandom_range(7))
              0:       p[j] = PosW'(lo);
              1:       p[j] = PosW'(hi);
              default: p[j] = PosW'(lo + $urandom_range(hi - lo));
            endcase
          end
        end
        default: p[j] = PosW'($urandom);
      endcase
    end
    if (mode == POSE_MISS) begin
      bad = $urandom_range(JointCount - 1);
      lo  = sb.limit(1'b0, bad);
      hi  = sb.limit(1'b1, bad);
      if (lo > -32768 && (hi == 32767 || $urandom_range(1) == 0)) begin
        p[bad] = PosW'(lo - 1);
      end else if (hi < 32767) begin
        p[bad] = PosW'(hi + 1);
      end
    end
    return p;
  endfunction

  task automatic send(req_type_e kind, logic wanted, pose_t pos);
    if (!calm && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= kind;
    enable_wanted_i <= wanted;
    joint_drv       <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // mostly sample/grant/tick/publish sessions, the rest noise
  task automatic random_items(int count);
    int stop;
    stop = sent + count;
    while (sent < stop) begin
      if ($urandom_range(9) < 7) begin
        send(REQ_SAMPLE, 1'($urandom_range(1)),
             pick_pose(($urandom_range(4) == 0) ? POSE_MISS : POSE_FIT));
        send(REQ_ENABLE, 1'b1, pick_pose(POSE_NOISE));
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(9))
            0, 1, 2: repeat ($urandom_range(1, 3))
                       send(REQ_TICK, 1'($urandom_range(1)), pick_pose(POSE_NOISE));
            3, 4, 5, 6: send(REQ_PUBLISH, 1'($urandom_range(1)), pick_pose(POSE_NOISE));
            7: send(REQ_SAMPLE, 1'($urandom_range(1)), pick_pose(POSE_FIT));
            default: send(REQ_ENABLE, 1'($urandom_range(3) != 0), pick_pose(POSE_NOISE));
          endcase
        end
      end else begin
        send(req_type_e'($urandom_range(3)), 1'($urandom_range(1)), pick_pose(POSE_NOISE));
      end
    end
  endtask

  initial begin : stimulus
    pose_t  lower_lim, upper_lim;
    joint_t lo_j, hi_j;
    sb              = new();
    sent            = 0;
    stall_cycles    = 0;
    calm            = 1'b0;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    req_type_i      <= REQ_SAMPLE;
    enable_wanted_i <= 1'b0;
    joint_drv       <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CFG_TIMEOUT;
    cfg_data_i      <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // saturated age with the widest timeout: only the missing sample refuses
    write_cfg(CFG_TIMEOUT, 48'hFFFF);
    send(REQ_ENABLE, 1'b1, pick_pose(POSE_NOISE));
    send(REQ_PUBLISH, 1'b0, pick_pose(POSE_NOISE));
    settle();
    write_cfg(CFG_TIMEOUT, CfgDataW'(RST_TIMEOUT));

    send(REQ_SAMPLE, 1'b0, {JointCount{16'h8000}});
    send(REQ_SAMPLE, 1'b1, {JointCount{16'h7FFF}});
    send(REQ_SAMPLE, 1'b0, pick_pose(POSE_MISS));
    send(REQ_SAMPLE, 1'b0, pick_pose(POSE_MISS));
    send(REQ_ENABLE, 1'b1, pick_pose(POSE_NOISE));
    send(REQ_SAMPLE, 1'b0, pick_pose(POSE_LOWER));
    send(REQ_SAMPLE, 1'b0, pick_pose(POSE_UPPER));
    send(REQ_TICK, 1'b0, pick_pose(POSE_NOISE));
    send(REQ_PUBLISH, 1'b0, pick_pose(POSE_NOISE));
    send(REQ_ENABLE, 1'b1, pick_pose(POSE_NOISE));
    send(REQ_PUBLISH, 1'b1, pick_pose(POSE_NOISE));
    send(REQ_TICK, 1'b1, pick_pose(POSE_NOISE));
    send(REQ_PUBLISH, 1'b0, pick_pose(POSE_NOISE));
    send(REQ_ENABLE, 1'b0, pick_pose(POSE_NOISE));
    send(REQ_PUBLISH, 1'b0, pick_pose(POSE_NOISE));
    send(REQ_ENABLE, 1'b0, pick_pose(POSE_NOISE));
    send(REQ_ENABLE, 1'b1, pick_pose(POSE_NOISE));
    send(REQ_SAMPLE, 1'b1, pick_pose(POSE_FIT));
    send(REQ_PUBLISH, 1'b1, pick_pose(POSE_NOISE));
    settle();

    // short timeout and lease so data and lease expire often
    write_cfg(CFG_TIMEOUT, 48'd3);
    write_cfg(CFG_LEASE, 48'd4);
    write_cfg(CFG_LOWER_A, RST_LOWER_A);
    write_cfg(CFG_LOWER_B, RST_LOWER_B);
    write_cfg(CFG_UPPER_A, RST_UPPER_A);
    write_cfg(CFG_UPPER_B, RST_UPPER_B);
    random_items(250);

    // receiver holds off while replies pile up
    send(REQ_SAMPLE, 1'b0, pick_pose(POSE_FIT));
    stall_cycles = 300;
    repeat (40) send(REQ_ENABLE, 1'($urandom_range(1)), pick_pose(POSE_NOISE));
    settle();

    write_cfg(CFG_TIMEOUT, 48'd1);
    write_cfg(CFG_LEASE, 48'd1);
    random_items(150);
    settle();

    // zero lease: grants pass but every publish drops them
    write_cfg(CFG_TIMEOUT, 48'd65534);
    write_cfg(CFG_LEASE, 48'd0);
    random_items(100);
    settle();
    write_cfg(CFG_LEASE, 48'd2047);
    random_items(100);

    // random limits, some inverted, with no idling on either side
    calm = 1'b1;
    for (int round = 0; round < 3; round++) begin
      settle();
      for (int j = 0; j < JointCount; j++) begin
        lo_j = joint_t'($urandom);
        hi_j = joint_t'($urandom);
        if (lo_j > hi_j && $urandom_range(4) != 0) begin
          lower_lim[j] = hi_j;
          upper_lim[j] = lo_j;
        end else begin
          lower_lim[j] = lo_j;
          upper_lim[j] = hi_j;
        end
      end
      write_cfg(CFG_LOWER_A, {lower_lim[2], lower_lim[1], lower_lim[0]});
      write_cfg(CFG_LOWER_B, {lower_lim[5], lower_lim[4], lower_lim[3]});
      write_cfg(CFG_UPPER_A, {upper_lim[2], upper_lim[1], upper_lim[0]});
      write_cfg(CFG_UPPER_B, {upper_lim[5], upper_lim[4], upper_lim[3]});
      write_cfg(CFG_TIMEOUT, {32'($urandom), 16'($urandom_range(1, 12))});
      write_cfg(CFG_LEASE, {37'($urandom), 11'($urandom_range(1, 12))});
      random_items(80);
    end
    settle();

    // open limits, widest timeout and lease
    write_cfg(CFG_LOWER_A, 48'h8000_8000_8000);
    write_cfg(CFG_LOWER_B, 48'h8000_8000_8000);
    write_cfg(CFG_UPPER_A, 48'h7FFF_7FFF_7FFF);
    write_cfg(CFG_UPPER_B, 48'h7FFF_7FFF_7FFF);
    write_cfg(CFG_TIMEOUT, 48'hFFFF);
    write_cfg(CFG_LEASE, 48'h7FF);
    send(REQ_SAMPLE, 1'b0, pick_pose(POSE_NOISE));
    repeat (20) send(REQ_TICK, 1'($urandom_range(1)), pick_pose(POSE_NOISE));
    send(REQ_ENABLE, 1'b1, pick_pose(POSE_NOISE));
    send(REQ_PUBLISH, 1'b0, pick_pose(POSE_NOISE));
    calm = 1'b0;
    settle();
    write_cfg(CFG_TIMEOUT, 48'hFFFE);
    write_cfg(CFG_SPARE_LO, {16'($urandom), 32'($urandom)});
    write_cfg(CFG_SPARE_HI, {16'($urandom), 32'($urandom)});
    send(REQ_ENABLE, 1'b1, pick_pose(POSE_NOISE));
    send(REQ_PUBLISH, 1'b1, pick_pose(POSE_NOISE));
    settle();

    write_cfg(CFG_TIMEOUT, CfgDataW'(RST_TIMEOUT));
    write_cfg(CFG_LEASE, CfgDataW'(RST_LEASE));
    write_cfg(CFG_LOWER_A, RST_LOWER_A);
    write_cfg(CFG_LOWER_B, RST_LOWER_B);
    write_cfg(CFG_UPPER_A, RST_UPPER_A);
    write_cfg(CFG_UPPER_B, RST_UPPER_B);
    random_items(200);
    settle();

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- teleop_lease_safety_gate_core.f -----
hw/rtl/tlsg_pkg.sv
hw/rtl/teleop_lease_safety_gate_core.sv
test/teleop_lease_safety_gate_core_tb.sv
